@@ hdl/tdrb_pkg.sv @@
// ----------------------------------------------------------------------------
// tdrb_pkg
// Shared types and constants for the tagged debug ring buffer.
// ----------------------------------------------------------------------------
package tdrb_pkg;

	localparam int unsigned DEPTH_DEFAULT = 240;
	localparam logic [7:0]  MARKER_RESET  = 8'd126;

	// action codes
	localparam logic [2:0] ACT_CHAR  = 3'd0;
	localparam logic [2:0] ACT_VALUE = 3'd1;
	localparam logic [2:0] ACT_READ  = 3'd2;
	localparam logic [2:0] ACT_QUERY = 3'd3;
	localparam logic [2:0] ACT_CLEAR = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the input item
		logic put;       // attempt one byte store
		logic src_text;  // byte comes from the text byte, else from the record shifter
		logic str_char;  // put of a string character: track drop and count
		logic str_end;   // string terminator: reset string tracking
		logic rd_req;    // pop one byte
		logic clear;     // empty the buffer
		logic finish;    // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] action;
		logic       text_zero;
		logic       vw_zero;
		logic       empty;
		logic       full;
		logic       dropping;
		logic       char_limit;
		logic       seq_last;
		logic       out_free;
	} stat_t;

endpackage

@@ hdl/tdrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdrb_ctrl
// Sequencer: takes one item, steps the datapath through its byte stores or
// its read, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tdrb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tdrb_pkg::stat_t stat,
	output tdrb_pkg::cmd_t  cmd
);
	import tdrb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				unique case (stat.action)
					ACT_CHAR: begin
						cmd.src_text = 1'b1;
						if (stat.text_zero) begin
							cmd.put     = 1'b1;
							cmd.str_end = 1'b1;
						end else if (!stat.dropping && !stat.char_limit) begin
							cmd.put      = 1'b1;
							cmd.str_char = 1'b1;
						end
					end
					ACT_VALUE: begin
						if (!stat.vw_zero) begin
							cmd.put = 1'b1;
							// record stops at the first dropped byte
							if (!stat.full && !stat.seq_last) begin
								state_d = S_EXEC;
							end
						end
					end
					ACT_READ: begin
						if (!stat.empty) begin
							cmd.rd_req = 1'b1;
						end
					end
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	sva_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> in_valid && in_ready)
		else $error("capture outside idle");

	sva_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_EXEC)
		else $error("item did not start");

	sva_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result loaded over a waiting result");

endmodule

@@ hdl/tdrb_dpath.sv @@
// ----------------------------------------------------------------------------
// tdrb_dpath
// Byte store, ring indices, string tracking, record shifter and result
// register.
// ----------------------------------------------------------------------------
module tdrb_dpath #(
	parameter int unsigned DEPTH = tdrb_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tdrb_pkg::cmd_t  cmd,
	output tdrb_pkg::stat_t stat,
	input  logic [2:0]      action,
	input  logic [7:0]      text_byte,
	input  logic [31:0]     value,
	input  logic [1:0]      value_width,
	input  logic [7:0]      size_cap,
	input  logic            cfg_valid,
	input  logic [7:0]      cfg_data,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [7:0]      read_data,
	output logic            read_stop,
	output logic [7:0]      read_size,
	output logic            write_dropped
);
	import tdrb_pkg::*;

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// control state
	logic [IDX_W-1:0] wr_q, rd_q;
	logic             empty_q, dropping_q, drop_q, stop_q, out_valid_q;
	logic [CNT_W-1:0] char_q;
	logic [2:0]       cnt_q;
	logic [7:0]       marker_q;

	// item registers
	logic [2:0]  act_q;
	logic [7:0]  text_q, max_q;
	logic [39:0] seq_q;
	logic        vwz_q;

	logic [39:0] seq_d;
	logic [2:0]  cnt_d;

	logic [IDX_W-1:0] wr_next, wr_prev, rd_next;
	logic             full;
	logic [7:0]       put_byte;

	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [7:0]       mem_wd;
	logic [7:0]       mem [DEPTH];
	logic [7:0]       mem_rd_q;

	logic [CNT_W-1:0] sz;
	logic [7:0]       sz8, size_clamp;

	assign wr_next = (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + IDX_W'(1);
	assign wr_prev = (wr_q == '0) ? IDX_W'(DEPTH - 1) : wr_q - IDX_W'(1);
	assign rd_next = (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + IDX_W'(1);
	assign full    = !empty_q && (wr_q == rd_q);

	assign put_byte = cmd.src_text ? text_q : seq_q[39:32];

	// tag byte on top, value left aligned below it, one byte out per store
	always_comb begin
		unique case (value_width)
			2'd1: begin
				seq_d = {6'd0, value_width, value[7:0], 24'd0};
				cnt_d = 3'd2;
			end
			2'd2: begin
				seq_d = {6'd0, value_width, value[15:0], 16'd0};
				cnt_d = 3'd3;
			end
			default: begin
				seq_d = {6'd0, value_width, value};
				cnt_d = 3'd5;
			end
		endcase
	end

	// on overflow the newest stored byte becomes the marker
	always_comb begin
		mem_we = cmd.put;
		mem_wa = full ? wr_prev : wr_q;
		mem_wd = full ? marker_q : put_byte;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd_req) begin
			mem_rd_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			empty_q    <= 1'b1;
			dropping_q <= 1'b0;
			char_q     <= '0;
			drop_q     <= 1'b0;
			stop_q     <= 1'b0;
			cnt_q      <= '0;
			marker_q   <= MARKER_RESET;
		end else begin
			if (cfg_valid) begin
				marker_q <= cfg_data;
			end
			if (cmd.capture) begin
				drop_q <= 1'b0;
				stop_q <= empty_q;
				cnt_q  <= cnt_d;
			end
			if (cmd.put) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					wr_q    <= wr_next;
					empty_q <= 1'b0;
				end
				if (!cmd.src_text) begin
					cnt_q <= cnt_q - 3'd1;
				end
			end
			if (cmd.str_char) begin
				if (full) begin
					dropping_q <= 1'b1;
				end else begin
					char_q <= char_q + CNT_W'(1);
				end
			end
			if (cmd.str_end) begin
				dropping_q <= 1'b0;
				char_q     <= '0;
			end
			if (cmd.rd_req) begin
				rd_q <= rd_next;
				if (wr_q == rd_next) begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				wr_q       <= '0;
				rd_q       <= '0;
				empty_q    <= 1'b1;
				dropping_q <= 1'b0;
				char_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			text_q <= text_byte;
			max_q  <= size_cap;
			vwz_q  <= (value_width == 2'd0);
			seq_q  <= seq_d;
		end else if (cmd.put && !cmd.src_text) begin
			seq_q <= {seq_q[31:0], 8'd0};
		end
	end

	// occupancy, clamped
	always_comb begin
		if (wr_q == rd_q) begin
			sz = CNT_W'(DEPTH);
		end else if (wr_q > rd_q) begin
			sz = CNT_W'(wr_q - rd_q);
		end else begin
			sz = CNT_W'(DEPTH) - CNT_W'(rd_q - wr_q);
		end
		sz8        = empty_q ? 8'd0 : 8'(sz);
		size_clamp = (sz8 > max_q) ? max_q : sz8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			read_data     <= (act_q == ACT_READ && !stop_q) ? mem_rd_q : 8'd0;
			read_stop     <= (act_q == ACT_READ) && stop_q;
			read_size     <= (act_q == ACT_QUERY) ? size_clamp : 8'd0;
			write_dropped <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat            = '0;
		stat.action     = act_q;
		stat.text_zero  = (text_q == 8'd0);
		stat.vw_zero    = vwz_q;
		stat.empty      = empty_q;
		stat.full       = full;
		stat.dropping   = dropping_q;
		stat.char_limit = (char_q == CNT_W'(DEPTH));
		stat.seq_last   = (cnt_q == 3'd1);
		stat.out_free   = !out_valid_q || out_ready;
	end

	sva_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put && full |=> $stable(wr_q) && $stable(rd_q) && drop_q)
		else $error("overflowing store moved the write index");

	sva_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_req |-> !empty_q)
		else $error("pop from empty buffer");

	sva_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> empty_q && wr_q == '0 && rd_q == '0 && !dropping_q)
		else $error("clear left state behind");

	sva_char_bound: assert property (@(posedge clk) disable iff (!arst_n)
		char_q <= CNT_W'(DEPTH))
		else $error("string count beyond depth");

endmodule

@@ hdl/tagged_debug_ring_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// tagged_debug_ring_buffer_unit
// Byte ring buffer for log strings and tagged value records.
// ----------------------------------------------------------------------------
// One item is in work at a time: it is taken in, then the datapath makes
// its byte stores one after another or its read, and then the result
// register is loaded once the output is free. A string character makes at
// most one byte store; a value record stores a tag plus 1, 2 or 4 bytes
// through the single write port of the byte store. A new item is taken while the
// previous result still waits at the output. The byte store needs no
// clearing after reset; the overflow marker may be written at any time the
// block is idle.
module tagged_debug_ring_buffer_unit #(
	parameter int unsigned DEPTH = tdrb_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  text_byte,
	input  logic [31:0] value,
	input  logic [1:0]  value_width,
	input  logic [7:0]  size_cap,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        read_stop,
	output logic [7:0]  read_size,
	output logic        write_dropped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import tdrb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	tdrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdrb_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.text_byte     (text_byte),
		.value         (value),
		.value_width   (value_width),
		.size_cap      (size_cap),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.read_data     (read_data),
		.read_stop     (read_stop),
		.read_size     (read_size),
		.write_dropped (write_dropped)
	);

endmodule

@@ sim/tdrb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdrb_checker
// Keeps its own copy of the log ring and overflow marker, predicts the reply
// to every accepted request item and compares it with the reply items taken
// from the unit, in order.
// ----------------------------------------------------------------------------
module tdrb_checker #(
	parameter int unsigned DEPTH = tdrb_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  text_byte,
	input  logic [31:0] value,
	input  logic [1:0]  value_width,
	input  logic [7:0]  size_cap,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic        read_stop,
	input  logic [7:0]  read_size,
	input  logic        write_dropped,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int unsigned fail_count,
	output int unsigned replies_pending
);

	localparam logic [1:0] VW_NONE = 2'd0;
	localparam logic [1:0] VW_WORD = 2'd3;
	localparam int unsigned PRINT_CAP = 40;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct {
		logic [7:0]  data;
		logic        stop;
		logic [7:0]  size;
		logic        dropped;
		int unsigned seq;
	} ring_reply_t;

	logic [7:0]  ring_mem [DEPTH];
	int unsigned wr_pos;
	int unsigned rd_pos;
	logic        ring_empty;
	logic        str_skip;
	int unsigned str_len;
	logic [7:0]  marker_byte;
	int unsigned requests_seen;
	ring_reply_t replies_due [$];

	function automatic int unsigned step_pos(input int unsigned p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	function automatic void clear_ring();
		wr_pos     = 0;
		rd_pos     = 0;
		ring_empty = 1'b1;
		str_skip   = 1'b0;
		str_len    = 0;
	endfunction

	// returns 1 when the byte is dropped because the ring is full
	function automatic logic push_byte(input logic [7:0] b);
		if (ring_empty) begin
			ring_empty = 1'b0;
		end else if (wr_pos == rd_pos) begin
			ring_mem[IDX_W'((wr_pos == 0) ? DEPTH - 1 : wr_pos - 1)] = marker_byte;
			return 1'b1;
		end
		ring_mem[IDX_W'(wr_pos)] = b;
		wr_pos = step_pos(wr_pos);
		return 1'b0;
	endfunction

	function automatic ring_reply_t predict_reply(input logic [2:0] act,
			input logic [7:0] txt, input logic [31:0] val, input logic [1:0] vw,
			input logic [7:0] lim);
		ring_reply_t r;
		int unsigned nbytes;
		int unsigned fill;
		r.data    = '0;
		r.stop    = 1'b0;
		r.size    = '0;
		r.dropped = 1'b0;
		r.seq     = 0;
		case (act)
			tdrb_pkg::ACT_CHAR: begin
				if (txt == 8'h00) begin
					// terminator is always attempted and closes the string
					r.dropped = push_byte(8'h00);
					str_skip  = 1'b0;
					str_len   = 0;
				end else if (!str_skip && str_len < DEPTH) begin
					if (push_byte(txt)) begin
						r.dropped = 1'b1;
						str_skip  = 1'b1;
					end else begin
						str_len++;
					end
				end
			end
			tdrb_pkg::ACT_VALUE: begin
				if (vw != VW_NONE) begin
					nbytes = (vw == VW_WORD) ? 4 : vw;
					if (push_byte({6'b0, vw})) begin
						r.dropped = 1'b1;
					end else begin
						// most significant byte first, stop at the first drop
						for (int k = nbytes; k > 0; k--) begin
							if (push_byte(val[(k - 1) * 8 +: 8])) begin
								r.dropped = 1'b1;
								break;
							end
						end
					end
				end
			end
			tdrb_pkg::ACT_READ: begin
				if (ring_empty) begin
					r.stop = 1'b1;
				end else begin
					r.data = ring_mem[IDX_W'(rd_pos)];
					rd_pos = step_pos(rd_pos);
					if (wr_pos == rd_pos)
						ring_empty = 1'b1;
				end
			end
			tdrb_pkg::ACT_QUERY: begin
				if (!ring_empty) begin
					if (wr_pos == rd_pos)
						fill = DEPTH;
					else if (wr_pos > rd_pos)
						fill = wr_pos - rd_pos;
					else
						fill = DEPTH - (rd_pos - wr_pos);
					r.size = (fill > lim) ? lim : fill[7:0];
				end
			end
			tdrb_pkg::ACT_CLEAR: begin
				clear_ring();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned seq,
			input logic [31:0] got, input logic [31:0] want);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("mismatch at %0t ns, item %0d: %s got 0x%0h expected 0x%0h",
				$time, seq, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_reply_t want;
		if (!arst_n) begin
			ring_mem = '{default: 8'h00};
			clear_ring();
			marker_byte = tdrb_pkg::MARKER_RESET;
			replies_due.delete();
			requests_seen   = 0;
			fail_count      = 0;
			replies_pending = 0;
		end else begin
			// reply first: it belongs to an earlier item than any taken now
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					flag_mismatch("reply with no item waiting", requests_seen, 32'd0, 32'd0);
				end else begin
					want = replies_due.pop_front();
					if (read_data !== want.data)
						flag_mismatch("read_data", want.seq, 32'(read_data),
							32'(want.data));
					if (read_stop !== want.stop)
						flag_mismatch("read_stop", want.seq, 32'(read_stop),
							32'(want.stop));
					if (read_size !== want.size)
						flag_mismatch("read_size", want.seq, 32'(read_size),
							32'(want.size));
					if (write_dropped !== want.dropped)
						flag_mismatch("write_dropped", want.seq, 32'(write_dropped),
							32'(want.dropped));
				end
			end
			if (cfg_valid && cfg_ready)
				marker_byte = cfg_data;
			if (in_valid && in_ready) begin
				want = predict_reply(action, text_byte, value, value_width, size_cap);
				want.seq = requests_seen;
				requests_seen++;
				replies_due.push_back(want);
			end
			replies_pending = replies_due.size();
		end
	end

endmodule

@@ sim/tb_tagged_debug_ring_buffer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_debug_ring_buffer_unit
// Drives log strings, value records, reads, size queries and clears into the
// ring buffer unit with random gaps and stalls on both channels, rewrites the
// overflow marker between phases, and leaves all checking to tdrb_checker.
// ----------------------------------------------------------------------------
module tb_tagged_debug_ring_buffer_unit;

	localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;
	localparam int unsigned RING_DEPTH      = tdrb_pkg::DEPTH_DEFAULT;
	localparam int unsigned ITEM_TARGET     = 1600;
	localparam int unsigned FILL_ITEMS      = 200;
	localparam int unsigned DRAIN_ITEMS     = 100;
	localparam int unsigned LONG_HOLD       = 400;
	localparam int unsigned SETTLE_CYCLES   = 12;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [7:0]  text_byte;
	logic [31:0] value;
	logic [1:0]  value_width;
	logic [7:0]  size_cap;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_data;
	logic        read_stop;
	logic [7:0]  read_size;
	logic        write_dropped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	int unsigned fail_count;
	int unsigned replies_pending;
	int unsigned items_sent;
	int unsigned replies_taken;
	int unsigned rx_hold;
	bit          tx_calm;
	bit          rx_calm;

	tagged_debug_ring_buffer_unit u_dut (.*);

	tdrb_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tagged_debug_ring_buffer_unit regression: fail");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_item(input logic [2:0] act, input logic [7:0] txt,
			input logic [31:0] val, input logic [1:0] vw, input logic [7:0] lim);
		int unsigned gap;
		@(negedge clk);
		action      = act;
		text_byte   = txt;
		value       = val;
		value_width = vw;
		size_cap    = lim;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_loose(input logic [2:0] act);
		send_item(act, 8'($urandom), $urandom, 2'($urandom), 8'($urandom));
	endtask

	task automatic send_char(input logic [7:0] c);
		send_item(tdrb_pkg::ACT_CHAR, c, $urandom, 2'($urandom), 8'($urandom));
	endtask

	task automatic wait_until_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (replies_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_marker(input logic [7:0] m);
		wait_until_quiet();
		cfg_data  = m;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_string();
		int unsigned len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		repeat (len) send_char(8'($urandom_range(1, 255)));
		// some strings are left open and run into the next one
		if ($urandom_range(0, 9) != 0)
			send_char(8'h00);
	endtask

	task automatic send_record();
		logic [1:0] vw;
		vw = ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		send_item(tdrb_pkg::ACT_VALUE, 8'($urandom), $urandom, vw, 8'($urandom));
	endtask

	task automatic send_query();
		int unsigned r;
		logic [7:0]  lim;
		r = $urandom_range(0, 9);
		lim = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
		send_item(tdrb_pkg::ACT_QUERY, 8'($urandom), $urandom, 2'($urandom), lim);
	endtask

	task automatic run_phase(input bit filling);
		int unsigned start;
		int unsigned quota;
		int unsigned r;
		start = items_sent;
		quota = filling ? FILL_ITEMS : DRAIN_ITEMS;
		while (items_sent - start < quota) begin
			r = $urandom_range(0, 99);
			if (r < (filling ? 35 : 12))
				send_string();
			else if (r < (filling ? 80 : 24))
				send_record();
			else if (r < (filling ? 86 : 80))
				repeat ($urandom_range(1, 6)) send_loose(tdrb_pkg::ACT_READ);
			else if (r < (filling ? 96 : 92))
				send_query();
			else if (!filling && r < 94)
				send_loose(tdrb_pkg::ACT_CLEAR);
			else
				send_loose(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
		end
	endtask

	// one string longer than the ring, drained as it goes, so the length cap hits
	task automatic run_long_string();
		send_loose(tdrb_pkg::ACT_CLEAR);
		repeat (RING_DEPTH + 16) begin
			send_char(8'($urandom_range(1, 255)));
			send_loose(tdrb_pkg::ACT_READ);
		end
		send_char(8'h00);
		repeat (3) send_loose(tdrb_pkg::ACT_READ);
	endtask

	initial begin
		int unsigned phase;
		logic [7:0]  marker;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = tdrb_pkg::ACT_READ;
		text_byte   = '0;
		value       = '0;
		value_width = '0;
		size_cap    = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		items_sent  = 0;
		tx_calm     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty ring, field extremes, every action, tag zero
		send_loose(tdrb_pkg::ACT_READ);
		send_item(tdrb_pkg::ACT_QUERY, 8'($urandom), $urandom, 2'($urandom), 8'hFF);
		send_char(8'hFF);
		send_char(8'h01);
		send_char(8'h80);
		send_char(8'h00);
		for (int w = 0; w < 4; w++)
			send_item(tdrb_pkg::ACT_VALUE, 8'($urandom),
				w[0] ? 32'hFFFF_FFFF : 32'h8000_0001, 2'(w), 8'($urandom));
		send_item(tdrb_pkg::ACT_QUERY, 8'($urandom), $urandom, 2'($urandom), 8'h00);
		send_item(tdrb_pkg::ACT_QUERY, 8'($urandom), $urandom, 2'($urandom), 8'hFF);
		send_item(tdrb_pkg::ACT_QUERY, 8'($urandom), $urandom, 2'($urandom), 8'h02);
		repeat (4) send_loose(tdrb_pkg::ACT_READ);
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_item(3'(a), 8'hFF, 32'hFFFF_FFFF, 2'b11, 8'hFF);
		send_loose(tdrb_pkg::ACT_CLEAR);
		send_item(tdrb_pkg::ACT_QUERY, 8'($urandom), $urandom, 2'($urandom), 8'hFF);
		send_loose(tdrb_pkg::ACT_READ);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase % 3 == 0) begin
				marker = (phase % 9 == 0) ? 8'h00 : (phase % 9 == 3) ? 8'hFF : 8'($urandom);
				write_marker(marker);
			end
			tx_calm = ($urandom_range(0, 3) == 0);
			if (phase == 4)
				run_long_string();
			else
				run_phase(phase % 2 == 0);
			phase++;
		end

		wait_until_quiet();
		if (fail_count == 0)
			$display("tagged_debug_ring_buffer_unit regression: pass");
		else
			$display("tagged_debug_ring_buffer_unit regression: fail");
		$finish;
	end

	// reply side: random stalls, calm stretches, and two long hold-offs
	initial begin
		int unsigned cycle_no;
		out_ready     = 1'b0;
		rx_hold       = 0;
		rx_calm       = 1'b0;
		replies_taken = 0;
		cycle_no      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle_no++;
			if (cycle_no % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (rx_hold != 0) begin
				out_ready = 1'b0;
				rx_hold--;
			end else begin
				out_ready = rx_calm || ($urandom_range(0, 9) != 0);
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				replies_taken++;
				if (replies_taken == 150 || replies_taken == 900)
					rx_hold = LONG_HOLD;
				else if (!rx_calm)
					rx_hold = pick_gap();
			end
		end
	end

endmodule

@@ files.f @@
hdl/tdrb_pkg.sv
hdl/tdrb_ctrl.sv
hdl/tdrb_dpath.sv
hdl/tagged_debug_ring_buffer_unit.sv
sim/tdrb_checker.sv
sim/tb_tagged_debug_ring_buffer_unit.sv
